@@ rtl/core/gwde_pkg.sv @@
// ----------------------------------------------------------------------------
// gwde_pkg
// Types and constants shared by the gapped window difference energy filter.
// ----------------------------------------------------------------------------
package gwde_pkg;

	localparam int SUM_W      = 24;
	localparam int IDX_W      = 12;
	localparam int LAG_W      = 9;
	localparam int LAG_MAX    = 382;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = 3;
	localparam int OUTQ_LW    = 4;

	localparam logic [6:0]       WINDOW_LEN_RST = 7'd33;
	localparam logic [6:0]       GAP_LEN_RST    = 7'd15;
	localparam logic [IDX_W-1:0] RECORD_LEN_RST = 12'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LEN = 2'd0,
		CFG_GAP_LEN    = 2'd1,
		CFG_RECORD_LEN = 2'd2
	} cfg_reg_t;

	// derived settings, all from the register file
	typedef struct packed {
		logic [IDX_W-1:0] lastn;  // last sample number of a record
		logic [LAG_W-1:0] span;   // 2L+G
		logic [7:0]       lag_a;  // L+1
		logic [7:0]       lag_b;  // L+G
		logic [LAG_W-1:0] lag_c;  // 2L+G+1
	} cfg_t;

	typedef struct packed {
		logic                    last;
		logic signed [SUM_W-1:0] peak;
		logic signed [SUM_W-1:0] energy;
	} result_t;

endpackage

@@ rtl/core/gwde_ram.sv @@
// ----------------------------------------------------------------------------
// gwde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gwde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/gwde_cfg.sv @@
// ----------------------------------------------------------------------------
// gwde_cfg
// Register file for window, gap and record length, and the derived lags.
// ----------------------------------------------------------------------------
module gwde_cfg
	import gwde_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [6:0]       window_len_q;
	logic [6:0]       gap_len_q;
	logic [IDX_W-1:0] record_len_q;
	logic [LAG_W-1:0] span;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			gap_len_q    <= GAP_LEN_RST;
			record_len_q <= RECORD_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WINDOW_LEN: window_len_q <= cfg_data[6:0];
				CFG_GAP_LEN:    gap_len_q    <= cfg_data[6:0];
				CFG_RECORD_LEN: record_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign span = {1'b0, window_len_q, 1'b0} + {2'b00, gap_len_q};

	always_comb begin
		cfg.lastn = (record_len_q == '0) ? '0 : record_len_q - 1'b1;
		cfg.span  = span;
		cfg.lag_a = {1'b0, window_len_q} + 8'd1;
		cfg.lag_b = {1'b0, window_len_q} + {1'b0, gap_len_q};
		cfg.lag_c = span + 9'd1;
	end

endmodule

@@ rtl/core/gwde_outq.sv @@
// ----------------------------------------------------------------------------
// gwde_outq
// Result queue between the filter pipeline and the output stream.
// ----------------------------------------------------------------------------
module gwde_outq
	import gwde_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  result_t            push_data,
	output logic               out_valid,
	input  logic               out_ready,
	output result_t            out_data,
	output logic [OUTQ_LW-1:0] level
);

	result_t              mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_q;
	logic [OUTQ_AW-1:0]   rd_q;
	logic [OUTQ_LW-1:0]   cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign level     = cnt_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + OUTQ_LW'(push) - OUTQ_LW'(pop);
		end
	end

endmodule

@@ rtl/core/gwde_dp.sv @@
// ----------------------------------------------------------------------------
// gwde_dp
// Four-stage filter pipeline: record control and delay line, running sums,
// energy, peak tracking.
// ----------------------------------------------------------------------------
module gwde_dp
	import gwde_pkg::*;
#(
	parameter int DELAY_DEPTH = 512,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   in_first,
	input  cfg_t                   cfg,
	input  logic [OUTQ_LW-1:0]     q_level,
	output logic                   res_push,
	output result_t                res
);

	localparam int AW       = $clog2(DELAY_DEPTH);
	localparam int MW       = LAG_W + AW;
	localparam int MOD_STEPS = LAG_MAX / DELAY_DEPTH;

	function automatic logic [AW-1:0] lag_mod(input logic [LAG_W-1:0] lag);
		logic [MW-1:0] x;
		x = MW'(lag);
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (x >= MW'(DELAY_DEPTH)) begin
				x = x - MW'(DELAY_DEPTH);
			end
		end
		return x[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] rd_addr(input logic [AW-1:0] wp, input logic [AW-1:0] lm);
		logic [AW:0] s;
		s = {1'b0, wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, lm};
		if (s >= (AW+1)'(DELAY_DEPTH)) begin
			s = s - (AW+1)'(DELAY_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	logic [AW-1:0] lmod_a_q, lmod_b_q, lmod_c_q;

	// stage 1
	logic                          v_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          first_s1;
	logic                          done_q;
	logic [IDX_W-1:0]              idx_q;
	logic [AW-1:0]                 wp_q;
	logic [IDX_W-1:0]              n;
	logic [AW-1:0]                 wp;
	logic                          go;
	logic [SAMPLE_BITS-1:0]        rd_a, rd_b, rd_c;

	// stage 2
	logic                          v_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic                          first_s2, emit_s2, last_s2, pinit_s2;
	logic                          use_a_s2, use_b_s2, use_c_s2;
	logic                          byp_a_s2, byp_b_s2, byp_c_s2;
	logic signed [SUM_W-1:0]       lead_q, trail_q;
	logic signed [SUM_W-1:0]       x_e, da, db, dc, lead_base, trail_base;

	// stages 3 and 4
	logic                          v_s3, first_s3, emit_s3, last_s3, pinit_s3;
	logic                          v_s4, first_s4, emit_s4, last_s4, pinit_s4;
	logic signed [SUM_W-1:0]       e_s4;
	logic signed [SUM_W-1:0]       peak_q, peak_base, peak_new;
	logic [2:0]                    inflight;

	// credit against the result queue
	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign in_ready = (5'(q_level) + 5'(inflight)) < 5'(OUTQ_DEPTH);

	always_ff @(posedge clk) begin
		lmod_a_q <= lag_mod({1'b0, cfg.lag_a});
		lmod_b_q <= lag_mod({1'b0, cfg.lag_b});
		lmod_c_q <= lag_mod(cfg.lag_c);
	end

	// ---- stage 1: record control, delay line write and reads
	assign n  = first_s1 ? '0 : idx_q;
	assign wp = first_s1 ? '0 : wp_q;
	assign go = v_s1 && (first_s1 || !done_q);

	gwde_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_a (
		.clk(clk), .we(go), .waddr(wp), .wdata(sample_s1),
		.raddr(rd_addr(wp, lmod_a_q)), .rdata(rd_a)
	);
	gwde_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_b (
		.clk(clk), .we(go), .waddr(wp), .wdata(sample_s1),
		.raddr(rd_addr(wp, lmod_b_q)), .rdata(rd_b)
	);
	gwde_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_c (
		.clk(clk), .we(go), .waddr(wp), .wdata(sample_s1),
		.raddr(rd_addr(wp, lmod_c_q)), .rdata(rd_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b1;
			idx_q  <= '0;
			wp_q   <= '0;
		end else begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= go;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (go) begin
				if (n >= cfg.lastn) begin
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
					idx_q  <= n + 1'b1;
					wp_q   <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= in_sample;
		first_s1  <= in_first;

		sample_s2 <= sample_s1;
		first_s2  <= first_s1;
		use_a_s2  <= n >= IDX_W'(cfg.lag_a);
		use_b_s2  <= n >= IDX_W'(cfg.lag_b);
		use_c_s2  <= n >= IDX_W'(cfg.lag_c);
		byp_a_s2  <= (lmod_a_q == '0);
		byp_b_s2  <= (lmod_b_q == '0);
		byp_c_s2  <= (lmod_c_q == '0);
		emit_s2   <= (n >= IDX_W'(cfg.span)) && (n <= cfg.lastn);
		last_s2   <= (n == cfg.lastn);
		pinit_s2  <= (n == IDX_W'(cfg.span));

		first_s3  <= first_s2;
		emit_s3   <= emit_s2;
		last_s3   <= last_s2;
		pinit_s3  <= pinit_s2;

		first_s4  <= first_s3;
		emit_s4   <= emit_s3;
		last_s4   <= last_s3;
		pinit_s4  <= pinit_s3;
		e_s4      <= lead_q - trail_q;
	end

	// ---- stage 2: running sums; a lag of zero mod depth is the word just written
	always_comb begin
		x_e        = SUM_W'(sample_s2);
		da         = byp_a_s2 ? x_e : SUM_W'($signed(rd_a));
		db         = byp_b_s2 ? x_e : SUM_W'($signed(rd_b));
		dc         = byp_c_s2 ? x_e : SUM_W'($signed(rd_c));
		lead_base  = first_s2 ? '0 : lead_q;
		trail_base = first_s2 ? '0 : trail_q;
	end

	// ---- stage 4: peak
	always_comb begin
		peak_base = first_s4 ? '0 : peak_q;
		peak_new  = (pinit_s4 || (e_s4 > peak_base)) ? e_s4 : peak_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			trail_q <= '0;
			peak_q  <= '0;
		end else begin
			if (v_s2) begin
				lead_q  <= lead_base + x_e - (use_a_s2 ? da : '0);
				trail_q <= trail_base + (use_b_s2 ? db : '0) - (use_c_s2 ? dc : '0);
			end
			if (v_s4) begin
				peak_q <= emit_s4 ? peak_new : peak_base;
			end
		end
	end

	assign res_push   = v_s4 && emit_s4;
	assign res.energy = e_s4;
	assign res.peak   = peak_new;
	assign res.last   = last_s4;

`ifndef SYNTHESIS
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(5'(q_level) + 5'(inflight)) <= 5'(OUTQ_DEPTH))
		else $error("result credit exceeded");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (q_level < OUTQ_LW'(OUTQ_DEPTH)))
		else $error("push into full result queue");

	a_first_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && first_s1) |=> (done_q || (idx_q == IDX_W'(1))))
		else $error("record start did not restart the count");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && emit_s4) |=> (peak_q >= $past(e_s4)))
		else $error("peak below emitted energy");
`endif

endmodule

@@ rtl/core/gapped_window_difference_energy.sv @@
// ----------------------------------------------------------------------------
// gapped_window_difference_energy
// Trapezoidal shaping filter: leading minus trailing window sum per sample,
// with per-record peak tracking and a last flag on the final result.
// ----------------------------------------------------------------------------
//  port group  dir  word                        accepted when
//  s_*         in   tdata: sample; tuser: first s_tvalid & s_tready
//  m_*         out  tdata: energy, peak; tlast  m_tvalid & m_tready
//  cfg_*       in   cfg_index, cfg_data         cfg_valid & cfg_ready
//
//  One sample per cycle sustained while s_tready is high.
//  Four pipeline stages: delay line, running sums, energy, peak.
//  The delay line is three copies of one RAM, one read port each.
//  s_tready drops when the 8-word result queue plus the four stages hold 8 words.
//  Reset puts the lengths to 33/15/2000 and waits for a first sample.
// ----------------------------------------------------------------------------
module gapped_window_difference_energy
	import gwde_pkg::*;
#(
	parameter int DELAY_DEPTH = 512,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample
	input  logic                               s_tuser,   // first
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [2*SUM_W-1:0]                 m_tdata,   // energy, peak
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [CFG_IDX_W-1:0]               cfg_index,
	input  logic [CFG_DATA_W-1:0]              cfg_data
);

	cfg_t               cfg;
	logic               res_push;
	result_t            res;
	result_t            out_res;
	logic [OUTQ_LW-1:0] q_level;

	gwde_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gwde_dp #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[SAMPLE_BITS-1:0]),
		.in_first  (s_tuser),
		.cfg       (cfg),
		.q_level   (q_level),
		.res_push  (res_push),
		.res       (res)
	);

	gwde_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res),
		.level     (q_level)
	);

	assign m_tdata = {out_res.peak, out_res.energy};
	assign m_tlast = out_res.last;

endmodule
